### hw/rtl/krle_pkg.sv
package krle_pkg;

	typedef enum logic [1:0] {
		FUNC_APPEND = 2'd0,
		FUNC_DELETE = 2'd1,
		FUNC_SORT   = 2'd2,
		FUNC_DUMP   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	localparam int KEY_W   = 31;
	localparam int SMALL_W = 7;
	localparam logic [SMALL_W-1:0] SCORE_MAX = 7'd100;

	// One queued command between the front and back parts.
	typedef struct packed {
		func_t              func;
		logic [KEY_W-1:0]   key;
		logic [SMALL_W-1:0] age;
		logic [SMALL_W-1:0] score;
	} cmd_t;

	// One result item leaving the back part.
	typedef struct packed {
		status_t            status;
		logic [KEY_W-1:0]   key;
		logic [SMALL_W-1:0] age;
		logic [SMALL_W-1:0] score;
		logic [5:0]         count;
		logic               last;
	} res_t;

endpackage

### hw/rtl/krle_front.sv
// Front part: takes input items, saturates the score and keeps a two-entry queue.
module krle_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    func,
	input  logic [krle_pkg::KEY_W-1:0]    student_key,
	input  logic [krle_pkg::SMALL_W-1:0]  age,
	input  logic [krle_pkg::SMALL_W-1:0]  score_tenths,
	output logic                          cmd_valid,
	input  logic                          cmd_ready,
	output krle_pkg::cmd_t                cmd
);
	krle_pkg::cmd_t fifo_q [2];
	logic           wr_ptr_q, rd_ptr_q;
	logic [1:0]     fill_q;
	krle_pkg::cmd_t in_cmd;
	logic           push, pop;

	always_comb begin
		in_cmd.func  = krle_pkg::func_t'(func);
		in_cmd.key   = student_key;
		in_cmd.age   = age;
		in_cmd.score = (score_tenths > krle_pkg::SCORE_MAX) ? krle_pkg::SCORE_MAX
			: score_tenths;
	end

	assign in_ready  = (fill_q != 2'd2);
	assign cmd_valid = (fill_q != 2'd0);
	assign cmd       = fifo_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

### hw/rtl/krle_back.sv
// Back part: sequencer over the record memory.
module krle_back #(
	parameter int DEPTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  krle_pkg::cmd_t cmd,
	output logic           res_valid,
	input  logic           res_ready,
	output krle_pkg::res_t res
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int RW = krle_pkg::KEY_W + 2 * krle_pkg::SMALL_W;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b00000001,
		S_SRCH  = 8'b00000010,
		S_SHIFT = 8'b00000100,
		S_SRDI  = 8'b00001000,
		S_SCMP  = 8'b00010000,
		S_WBI   = 8'b00100000,
		S_DUMP  = 8'b01000000,
		S_OUT   = 8'b10000000
	} state_t;

	logic [RW-1:0]             mem_q [DEPTH];
	logic [RW-1:0]             rd_q;
	logic [RW-1:0]             reci_q;
	state_t                    state_q;
	logic [krle_pkg::KEY_W-1:0] key_q;
	krle_pkg::status_t         st_q;
	logic [CW-1:0]             cnt_q;
	logic [CW-1:0]             i_q, j_q;
	logic                      res_vld_q;
	krle_pkg::res_t            res_q;

	logic [AW-1:0]  rd_addr;
	logic           rd_en;
	logic           wr_en;
	logic [AW-1:0]  wr_addr;
	logic [RW-1:0]  wr_data;
	logic           out_free;
	logic           res_load;
	logic           swap;
	logic           hit;

	assign out_free  = !res_vld_q || res_ready;
	assign res_load  = ((state_q == S_DUMP) || (state_q == S_OUT)) && out_free;
	assign res_valid = res_vld_q;
	assign res       = res_q;
	assign cmd_ready = (state_q == S_IDLE);

	// Sort keeps record i in reci_q and writes it back when i moves on.
	assign swap = (reci_q[RW-1 -: krle_pkg::KEY_W] > rd_q[RW-1 -: krle_pkg::KEY_W]);
	assign hit  = (rd_q[RW-1 -: krle_pkg::KEY_W] == key_q);

	// Memory read address by state; the data shows up in rd_q in the next cycle.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		unique case (state_q)
			S_IDLE: begin
				rd_en   = cmd_valid;
				rd_addr = '0;
			end
			S_SRCH: begin
				rd_en   = 1'b1;
				rd_addr = i_q[AW-1:0] + AW'(1);
			end
			S_SHIFT: begin
				rd_en   = 1'b1;
				rd_addr = j_q[AW-1:0] + AW'(2);
			end
			S_SRDI: begin
				rd_en   = 1'b1;
				rd_addr = j_q[AW-1:0];
			end
			S_SCMP: begin
				rd_en   = 1'b1;
				rd_addr = j_q[AW-1:0] + AW'(1);
			end
			S_WBI: begin
				rd_en   = 1'b1;
				rd_addr = i_q[AW-1:0] + AW'(1);
			end
			S_DUMP: begin
				rd_en   = out_free;
				rd_addr = i_q[AW-1:0] + AW'(1);
			end
			S_OUT: begin
				rd_en   = 1'b0;
				rd_addr = '0;
			end
			default: begin
				rd_en   = 1'b0;
				rd_addr = '0;
			end
		endcase
	end

	// One memory write a cycle at most.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = rd_q;
		unique case (state_q)
			S_IDLE: begin
				wr_en   = cmd_valid && cmd.func == krle_pkg::FUNC_APPEND
					&& cnt_q < CW'(DEPTH);
				wr_addr = cnt_q[AW-1:0];
				wr_data = {cmd.key, cmd.age, cmd.score};
			end
			S_SHIFT: begin
				wr_en   = 1'b1;
				wr_addr = j_q[AW-1:0];
				wr_data = rd_q;
			end
			S_SCMP: begin
				wr_en   = swap;
				wr_addr = j_q[AW-1:0];
				wr_data = reci_q;
			end
			S_WBI: begin
				wr_en   = 1'b1;
				wr_addr = i_q[AW-1:0];
				wr_data = reci_q;
			end
			default: begin
				wr_en   = 1'b0;
				wr_addr = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_q <= mem_q[rd_addr];
		if (wr_en) mem_q[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			i_q     <= '0;
			j_q     <= '0;
			st_q    <= krle_pkg::ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						i_q <= '0;
						j_q <= CW'(1);
						unique case (cmd.func)
							krle_pkg::FUNC_APPEND: begin
								if (cnt_q < CW'(DEPTH)) begin
									cnt_q <= cnt_q + CW'(1);
									st_q  <= krle_pkg::ST_OK;
								end else begin
									st_q  <= krle_pkg::ST_FULL;
								end
								state_q <= S_OUT;
							end
							krle_pkg::FUNC_DELETE: begin
								st_q    <= krle_pkg::ST_NOT_FOUND;
								state_q <= (cnt_q == '0) ? S_OUT : S_SRCH;
							end
							krle_pkg::FUNC_SORT: begin
								st_q    <= krle_pkg::ST_OK;
								state_q <= (cnt_q < CW'(2)) ? S_OUT : S_SRDI;
							end
							krle_pkg::FUNC_DUMP: begin
								st_q    <= krle_pkg::ST_EMPTY;
								state_q <= (cnt_q == '0) ? S_OUT : S_DUMP;
							end
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_SRCH: begin
					// rd_q holds record i.
					if (hit) begin
						st_q <= krle_pkg::ST_OK;
						j_q  <= i_q;
						if (i_q + CW'(1) >= cnt_q) begin
							cnt_q   <= cnt_q - CW'(1);
							state_q <= S_OUT;
						end else begin
							state_q <= S_SHIFT;
						end
					end else if (i_q + CW'(1) >= cnt_q) begin
						state_q <= S_OUT;
					end else begin
						i_q <= i_q + CW'(1);
					end
				end
				S_SHIFT: begin
					// rd_q holds record j+1, written to j this cycle.
					if (j_q + CW'(2) >= cnt_q) begin
						cnt_q   <= cnt_q - CW'(1);
						state_q <= S_OUT;
					end else begin
						j_q <= j_q + CW'(1);
					end
				end
				S_SRDI: state_q <= S_SCMP;
				S_SCMP: begin
					if (j_q + CW'(1) >= cnt_q) begin
						state_q <= S_WBI;
					end else begin
						j_q <= j_q + CW'(1);
					end
				end
				S_WBI: begin
					if (i_q + CW'(2) >= cnt_q) begin
						state_q <= S_OUT;
					end else begin
						i_q     <= i_q + CW'(1);
						j_q     <= i_q + CW'(2);
						state_q <= S_SRDI;
					end
				end
				S_DUMP: begin
					if (out_free) begin
						i_q <= i_q + CW'(1);
						if (i_q + CW'(1) == cnt_q) state_q <= S_IDLE;
					end
				end
				S_OUT: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_valid) key_q <= cmd.key;
		if (state_q == S_SRDI) begin
			reci_q <= rd_q;
		end else if (state_q == S_SCMP && swap) begin
			reci_q <= rd_q;
		end
		if (res_load) begin
			if (state_q == S_DUMP) begin
				res_q.status <= krle_pkg::ST_OK;
				res_q.key    <= rd_q[RW-1 -: krle_pkg::KEY_W];
				res_q.age    <= rd_q[2*krle_pkg::SMALL_W-1 -: krle_pkg::SMALL_W];
				res_q.score  <= rd_q[krle_pkg::SMALL_W-1:0];
				res_q.count  <= 6'(cnt_q);
				res_q.last   <= (i_q + CW'(1) == cnt_q);
			end else begin
				res_q.status <= st_q;
				res_q.key    <= '0;
				res_q.age    <= '0;
				res_q.score  <= '0;
				res_q.count  <= 6'(cnt_q);
				res_q.last   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (res_load) begin
			res_vld_q <= 1'b1;
		end else if (res_ready) begin
			res_vld_q <= 1'b0;
		end
	end
endmodule

### hw/rtl/keyed_record_list_engine.sv
// Channel | valid/ready        | payload
// input   | in_valid/in_ready  | func, student_key, age, score_tenths
// output  | out_valid/out_ready| status, out_key, out_age, out_score, count, last
//
// Once the back accepts a command, delete searches and shifts in one pass over the table,
// dump gives one item a cycle while out_ready stays high, and sort is an exchange sort
// over the records with one compare a cycle within each pass.
// Reset (arst_n, asynchronous) empties the table. A low out_ready stalls the back,
// and the two-item queue keeps accepting input items until it fills.
module keyed_record_list_engine #(
	parameter int DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [30:0] student_key,
	input  logic [6:0]  age,
	input  logic [6:0]  score_tenths,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [30:0] out_key,
	output logic [6:0]  out_age,
	output logic [6:0]  out_score,
	output logic [5:0]  count,
	output logic        last
);
	krle_pkg::cmd_t cmd;
	krle_pkg::res_t res;
	logic           cmd_valid, cmd_ready;

	// The front part saturates the score and queues items.
	krle_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .func, .student_key, .age,
		.score_tenths, .cmd_valid, .cmd_ready, .cmd
	);

	// The back part runs each command against the record memory.
	krle_back #(.DEPTH(DEPTH)) u_back (
		.clk, .arst_n, .cmd_valid, .cmd_ready, .cmd,
		.res_valid(out_valid), .res_ready(out_ready), .res
	);

	assign status    = res.status;
	assign out_key   = res.key;
	assign out_age   = res.age;
	assign out_score = res.score;
	assign count     = res.count;
	assign last      = res.last;

`ifndef SYNTHESIS
	// The record count never exceeds the table depth.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> {1'b0, count} <= 7'(DEPTH)) else $error("count above depth");
	// An error result carries a zero key and is marked last.
	a_status_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != krle_pkg::ST_OK) |-> (out_key == '0 && last))
		else $error("error result with data");
`endif
endmodule

### dv/tb_top.sv
module tb_top;

	localparam int DEPTH = 32;
	localparam int CYCLE_LIMIT = 3000000;

	// One record of the table and one pending input item.
	typedef struct packed {
		logic [30:0] key;
		logic [6:0]  age;
		logic [6:0]  score;
	} rec_t;

	typedef struct packed {
		krle_pkg::func_t func;
		logic [30:0] key;
		logic [6:0]  age;
		logic [6:0]  score;
	} cmd_item_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  func;
	logic [30:0] student_key;
	logic [6:0]  age;
	logic [6:0]  score_tenths;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic [30:0] out_key;
	logic [6:0]  out_age;
	logic [6:0]  out_score;
	logic [5:0]  count;
	logic        last;

	keyed_record_list_engine #(.DEPTH(DEPTH)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .student_key(student_key), .age(age), .score_tenths(score_tenths),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .out_key(out_key), .out_age(out_age), .out_score(out_score),
		.count(count), .last(last)
	);

	// Shadow copy of the table, kept in the order the block should hold it.
	rec_t      table_q[$];
	cmd_item_t pending_cmds[$];
	krle_pkg::res_t expected_results[$];
	logic [30:0] used_keys[$];
	int        mismatches;
	int        cycle_count;
	bit        stimulus_done;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Most gaps are short, about seven in a hundred are long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		else if (r < 93)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	function automatic krle_pkg::res_t make_result(krle_pkg::status_t st, rec_t r,
			logic lst);
		krle_pkg::res_t x;
		x.status = st;
		x.key = r.key;
		x.age = r.age;
		x.score = r.score;
		x.count = 6'(table_q.size());
		x.last = lst;
		return x;
	endfunction

	// Applies one accepted item to the shadow table and queues what it yields.
	task automatic predict_table_op(cmd_item_t c);
		rec_t r, blank, t;
		int   hit;
		blank = '0;
		case (c.func)
			krle_pkg::FUNC_APPEND: begin
				if (table_q.size() >= DEPTH) begin
					expected_results.push_back(make_result(krle_pkg::ST_FULL, blank, 1'b1));
				end else begin
					r.key = c.key;
					r.age = c.age;
					// Scores above ten point zero are saturated when stored.
					r.score = (c.score > krle_pkg::SCORE_MAX) ? krle_pkg::SCORE_MAX : c.score;
					table_q.push_back(r);
					expected_results.push_back(make_result(krle_pkg::ST_OK, blank, 1'b1));
				end
			end
			krle_pkg::FUNC_DELETE: begin
				hit = -1;
				foreach (table_q[i])
					if (hit < 0 && table_q[i].key == c.key)
						hit = i;
				if (hit < 0) begin
					expected_results.push_back(make_result(krle_pkg::ST_NOT_FOUND, blank,
						1'b1));
				end else begin
					table_q.delete(hit);
					expected_results.push_back(make_result(krle_pkg::ST_OK, blank, 1'b1));
				end
			end
			krle_pkg::FUNC_SORT: begin
				// Exchange sort, exactly as the block does it; not stable.
				for (int i = 0; i < table_q.size(); i++)
					for (int j = i + 1; j < table_q.size(); j++)
						if (table_q[i].key > table_q[j].key) begin
							t = table_q[i];
							table_q[i] = table_q[j];
							table_q[j] = t;
						end
				expected_results.push_back(make_result(krle_pkg::ST_OK, blank, 1'b1));
			end
			default: begin
				if (table_q.size() == 0)
					expected_results.push_back(make_result(krle_pkg::ST_EMPTY, blank, 1'b1));
				else
					foreach (table_q[i])
						expected_results.push_back(make_result(krle_pkg::ST_OK, table_q[i],
							i == table_q.size() - 1));
			end
		endcase
	endtask

	function automatic cmd_item_t build_cmd(krle_pkg::func_t f, logic [30:0] k,
			logic [6:0] a, logic [6:0] s);
		cmd_item_t c;
		c.func = f;
		c.key = k;
		c.age = a;
		c.score = s;
		return c;
	endfunction

	// Keys come from a small pool so deletes hit and sorts see duplicates.
	function automatic logic [30:0] pick_key();
		logic [30:0] k;
		if (used_keys.size() > 0 && $urandom_range(0, 3) != 0)
			return used_keys[$urandom_range(0, used_keys.size() - 1)];
		k = 31'($urandom());
		if ($urandom_range(0, 9) == 0)
			k = ($urandom_range(0, 1) != 0) ? 31'h7fffffff : 31'd0;
		used_keys.push_back(k);
		if (used_keys.size() > 40)
			void'(used_keys.pop_front());
		return k;
	endfunction

	initial begin
		krle_pkg::func_t f;
		// Directed part: empty dump, empty sort, missing delete, extremes of fields.
		pending_cmds.push_back(build_cmd(krle_pkg::FUNC_DUMP, 31'd0, 7'd0, 7'd0));
		pending_cmds.push_back(build_cmd(krle_pkg::FUNC_SORT, 31'd0, 7'd0, 7'd0));
		pending_cmds.push_back(build_cmd(krle_pkg::FUNC_DELETE, 31'd5, 7'd0, 7'd0));
		pending_cmds.push_back(build_cmd(krle_pkg::FUNC_APPEND, 31'h7fffffff, 7'h7f, 7'd100));
		pending_cmds.push_back(build_cmd(krle_pkg::FUNC_SORT, 31'd0, 7'd0, 7'd0));
		pending_cmds.push_back(build_cmd(krle_pkg::FUNC_APPEND, 31'd0, 7'd0, 7'd0));
		pending_cmds.push_back(build_cmd(krle_pkg::FUNC_APPEND, 31'h2aaaaaaa, 7'h55, 7'h7f));
		pending_cmds.push_back(build_cmd(krle_pkg::FUNC_APPEND, 31'h55555555, 7'h2a, 7'd101));
		pending_cmds.push_back(build_cmd(krle_pkg::FUNC_DUMP, 31'd0, 7'd0, 7'd0));
		pending_cmds.push_back(build_cmd(krle_pkg::FUNC_SORT, 31'd0, 7'd0, 7'd0));
		pending_cmds.push_back(build_cmd(krle_pkg::FUNC_DUMP, 31'd0, 7'd0, 7'd0));
		// Head and tail deletes after the sort.
		pending_cmds.push_back(build_cmd(krle_pkg::FUNC_DELETE, 31'd0, 7'd0, 7'd0));
		pending_cmds.push_back(build_cmd(krle_pkg::FUNC_DELETE, 31'h7fffffff, 7'd0, 7'd0));
		pending_cmds.push_back(build_cmd(krle_pkg::FUNC_DUMP, 31'd0, 7'd0, 7'd0));
		// Fill to the limit and two past it to see the full status.
		for (int i = 0; i < DEPTH - 1; i++)
			pending_cmds.push_back(build_cmd(krle_pkg::FUNC_APPEND, 31'(DEPTH - i), 7'(i),
				7'(i)));
		pending_cmds.push_back(build_cmd(krle_pkg::FUNC_APPEND, 31'd9, 7'd1, 7'd1));
		pending_cmds.push_back(build_cmd(krle_pkg::FUNC_DUMP, 31'd0, 7'd0, 7'd0));
		pending_cmds.push_back(build_cmd(krle_pkg::FUNC_SORT, 31'd0, 7'd0, 7'd0));
		pending_cmds.push_back(build_cmd(krle_pkg::FUNC_DUMP, 31'd0, 7'd0, 7'd0));
		// Random part: mostly appends and deletes, with the fill level wandering.
		for (int n = 0; n < 281; n++) begin
			case ($urandom_range(0, 19))
				0, 1: f = krle_pkg::FUNC_DUMP;
				2: f = krle_pkg::FUNC_SORT;
				3, 4, 5, 6, 7, 8: f = krle_pkg::FUNC_DELETE;
				default: f = krle_pkg::FUNC_APPEND;
			endcase
			pending_cmds.push_back(build_cmd(f, pick_key(), 7'($urandom()),
				($urandom_range(0, 4) == 0) ? 7'($urandom()) : 7'($urandom_range(0, 100))));
		end
	end

	// Driver: inputs change on the falling edge only.
	initial begin
		in_valid = 1'b0;
		func = '0;
		student_key = '0;
		age = '0;
		score_tenths = '0;
		out_ready = 1'b0;
		stimulus_done = 1'b0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	int in_gap;
	int out_gap;
	bit in_accepted;
	bit out_accepted;

	always @(negedge clk) begin
		if (arst_n) begin
			if (in_accepted || !in_valid) begin
				if (in_gap > 0) begin
					in_valid <= 1'b0;
					in_gap <= in_gap - 1;
				end else if (pending_cmds.size() > 0) begin
					in_valid <= 1'b1;
					func <= pending_cmds[0].func;
					student_key <= pending_cmds[0].key;
					age <= pending_cmds[0].age;
					score_tenths <= pending_cmds[0].score;
					void'(pending_cmds.pop_front());
					in_gap <= pick_gap();
				end else begin
					in_valid <= 1'b0;
					stimulus_done <= 1'b1;
				end
			end
			if (out_gap > 0) begin
				out_ready <= 1'b0;
				out_gap <= out_gap - 1;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 5) == 0)
					out_gap <= pick_gap();
			end
		end
	end

	// Monitor: sample both handshakes at the rising edge.
	always @(posedge clk) begin
		krle_pkg::res_t got, want;
		in_accepted <= 1'b0;
		if (arst_n && in_valid && in_ready) begin
			in_accepted <= 1'b1;
			predict_table_op(build_cmd(krle_pkg::func_t'(func), student_key, age,
				score_tenths));
		end
		if (arst_n && out_valid && out_ready) begin
			got.status = krle_pkg::status_t'(status);
			got.key = out_key;
			got.age = out_age;
			got.score = out_score;
			got.count = count;
			got.last = last;
			if (expected_results.size() == 0) begin
				mismatches = mismatches + 1;
				if (mismatches <= 10)
					$display("unexpected result item: %p", got);
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	initial begin
		in_gap = 0;
		out_gap = 0;
		in_accepted = 1'b0;
		mismatches = 0;
		cycle_count = 0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout waiting for the block");
			$display("*** FAILED ***");
			$finish;
		end
	end

	// End of run: stimulus accepted, every expected item seen, then a short drain.
	initial begin
		wait (stimulus_done && !in_valid);
		wait (expected_results.size() == 0);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

### files.f
hw/rtl/krle_pkg.sv
hw/rtl/krle_front.sv
hw/rtl/krle_back.sv
hw/rtl/keyed_record_list_engine.sv
dv/tb_top.sv
